FILE: sv/s2l_pkg.sv
// ----------------------------------------------------------------------------
// s2l_pkg
// constants, decode table and matrix coefficients for the srgb to cielab path
// ----------------------------------------------------------------------------
package s2l_pkg;

  localparam int FRAC_BITS = 7;
  localparam int QB        = 24;

  localparam int CODE_W   = 8;
  localparam int LIN_W    = QB + 1;
  localparam int MAT_W    = QB;
  localparam int PROD_W   = LIN_W + MAT_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int X_W      = QB + 2;
  localparam int F_W      = QB + 1;
  localparam int SQ_W     = 2 * F_W;
  localparam int Q_W      = SQ_W - QB;
  localparam int P_W      = Q_W + F_W;

  // linear branch of the cie f function
  localparam int EPS_W    = 18;
  localparam logic [X_W-1:0] EPS_X = X_W'((64'd8856 << QB) / 64'd1000000);
  localparam int KAPPA_W  = 14;
  localparam logic [KAPPA_W-1:0] KAPPA = KAPPA_W'(9033);
  localparam int N_W      = 32;
  localparam int N8_W     = N_W - 3;
  localparam logic [N_W-1:0] LIN_OFS = N_W'((64'd160 << QB) + 64'd580);
  localparam int RECIP_W  = 30;
  localparam int RECIP_SH = 37;
  localparam logic [RECIP_W-1:0] RECIP_145 =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd144) / 64'd145);
  localparam int LP_W     = N8_W + RECIP_W;

  // output scaling
  localparam int V_W      = 36;
  localparam int SH       = QB - FRAC_BITS;
  localparam int RM_W     = V_W - SH;
  localparam int LIGHT_W  = 14;
  localparam int CHROMA_W = 15;
  localparam int L_MAX_I  = ((100 << FRAC_BITS) > 16383) ? 16383 : (100 << FRAC_BITS);
  localparam logic [LIGHT_W-1:0] L_MAX = LIGHT_W'(L_MAX_I);
  localparam int CH_MAX_I = 16383;
  localparam int CH_MIN_MAG_I = 16384;

  typedef logic [LIN_W-1:0] lut_t [256];
  typedef logic [MAT_W-1:0] mat_t [3][3];

  // rows x, y, z already divided by the d65 white
  localparam mat_t MAT = '{
    '{MAT_W'(((64'd4124564 << 25) + 64'd9504560) / 64'd19009120),
      MAT_W'(((64'd3575761 << 25) + 64'd9504560) / 64'd19009120),
      MAT_W'(((64'd1804375 << 25) + 64'd9504560) / 64'd19009120)},
    '{MAT_W'(((64'd2126729 << 25) + 64'd10000000) / 64'd20000000),
      MAT_W'(((64'd7151522 << 25) + 64'd10000000) / 64'd20000000),
      MAT_W'(((64'd721750  << 25) + 64'd10000000) / 64'd20000000)},
    '{MAT_W'(((64'd193339  << 25) + 64'd10887540) / 64'd21775080),
      MAT_W'(((64'd1191920 << 25) + 64'd10887540) / 64'd21775080),
      MAT_W'(((64'd9503041 << 25) + 64'd10887540) / 64'd21775080)}
  };

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b) >> QB;
  endfunction

  function automatic logic [63:0] pow5(logic [63:0] r);
    logic [63:0] r2;
    r2 = qmul(r, r);
    return qmul(qmul(r2, r2), r);
  endfunction

  function automatic logic [63:0] root5(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] c;
    int          b;
    r = '0;
    for (b = QB; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ((c <= (64'd1 << QB)) && (pow5(c) <= s)) begin
        r = c;
      end
    end
    return r;
  endfunction

  // gamma decoding of every 8-bit code, evaluated at elaboration
  function automatic lut_t build_lut();
    lut_t        lut;
    logic [63:0] t;
    logic [63:0] s;
    int          v;
    for (v = 0; v < 256; v++) begin
      if (v <= 10) begin
        lut[v] = LIN_W'((((64'(v) * 64'd20) << QB) + 64'd32946) / 64'd65892);
      end else begin
        t = ((((64'd1000 * 64'(v)) + 64'd14025) << 25) + 64'd269025) / 64'd538050;
        s = qmul(t, t);
        lut[v] = LIN_W'(qmul(s, root5(s)));
      end
    end
    return lut;
  endfunction

  localparam lut_t LIN_LUT = build_lut();

endpackage

FILE: sv/s2l_linmat.sv
// ----------------------------------------------------------------------------
// s2l_linmat
// gamma decode table, white-normalised xyz matrix products and row sums
// ----------------------------------------------------------------------------
module s2l_linmat (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [s2l_pkg::CODE_W-1:0] red_i,
  input  logic [s2l_pkg::CODE_W-1:0] green_i,
  input  logic [s2l_pkg::CODE_W-1:0] blue_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [s2l_pkg::X_W-1:0]    x_o [3]
);

  localparam int NS = 3;

  logic [NS-1:0]                  vld_q;
  logic [NS:0]                    rdy;
  logic [s2l_pkg::CODE_W-1:0]     code [3];
  logic [s2l_pkg::LIN_W-1:0]      lin_q [3];
  logic [s2l_pkg::PROD_W-1:0]     prod_q [3][3];
  logic [s2l_pkg::ACC_W-1:0]      acc [3];
  logic [s2l_pkg::X_W-1:0]        x_q [3];

  assign code[0] = red_i;
  assign code[1] = green_i;
  assign code[2] = blue_i;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = s2l_pkg::ACC_W'(prod_q[i][0]) + s2l_pkg::ACC_W'(prod_q[i][1])
             + s2l_pkg::ACC_W'(prod_q[i][2])
             + (s2l_pkg::ACC_W'(1) << (s2l_pkg::QB - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (rdy[0]) begin
        lin_q[i] <= s2l_pkg::LIN_LUT[code[i]];
      end
      if (rdy[1]) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= s2l_pkg::PROD_W'(lin_q[j]) * s2l_pkg::PROD_W'(s2l_pkg::MAT[i][j]);
        end
      end
      if (rdy[2]) begin
        x_q[i] <= s2l_pkg::X_W'(acc[i] >> s2l_pkg::QB);
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];
  assign x_o         = x_q;

endmodule

FILE: sv/s2l_cief.sv
// ----------------------------------------------------------------------------
// s2l_cief
// cie f function: pipelined cube root, one result bit per stage, three lanes
// ----------------------------------------------------------------------------
module s2l_cief (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [s2l_pkg::X_W-1:0] x_i [3],
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [s2l_pkg::F_W-1:0] f_o [3]
);

  localparam int NR = s2l_pkg::F_W;
  localparam int NS = NR + 2;

  logic [NS-1:0]                   vld_q;
  logic [NS:0]                     rdy;

  logic [s2l_pkg::F_W-1:0]         r_d  [NR][3];
  logic [s2l_pkg::SQ_W-1:0]        sq_d [NR][3];
  logic [s2l_pkg::X_W-1:0]         xr_d [NR][3];
  logic [s2l_pkg::F_W-1:0]         r_q  [NR][3];
  logic [s2l_pkg::SQ_W-1:0]        sq_q [NR][3];
  logic [s2l_pkg::X_W-1:0]         xr_q [NR][3];

  logic                            small_d [3];
  logic [s2l_pkg::N_W-1:0]         n_d     [3];
  logic                            small_q [3];
  logic [s2l_pkg::N8_W-1:0]        n8_q    [3];
  logic [s2l_pkg::F_W-1:0]         rt_q    [3];
  logic [s2l_pkg::LP_W-1:0]        lp      [3];
  logic [s2l_pkg::F_W-1:0]         f_d     [3];
  logic [s2l_pkg::F_W-1:0]         f_q     [3];

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  for (genvar k = 0; k < NR; k++) begin : g_root
    localparam int B = NR - 1 - k;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [s2l_pkg::F_W-1:0]       r_in;
      logic [s2l_pkg::SQ_W-1:0]      sq_in;
      logic [s2l_pkg::X_W-1:0]       x_in;
      logic [s2l_pkg::F_W-1:0]       c;
      logic [s2l_pkg::SQ_W-1:0]      sq_c;
      logic [s2l_pkg::P_W-1:0]       p;
      logic                          take;
      if (k == 0) begin : g_first
        assign r_in  = '0;
        assign sq_in = '0;
        assign x_in  = x_i[i];
      end else begin : g_next
        assign r_in  = r_q[k-1][i];
        assign sq_in = sq_q[k-1][i];
        assign x_in  = xr_q[k-1][i];
      end
      // exact square of the candidate kept alongside the root
      assign c    = r_in | (s2l_pkg::F_W'(1) << B);
      assign sq_c = sq_in + (s2l_pkg::SQ_W'(r_in) << (B + 1))
                  + (s2l_pkg::SQ_W'(1) << (2 * B));
      assign p    = s2l_pkg::P_W'(sq_c[s2l_pkg::SQ_W-1:s2l_pkg::QB]) * s2l_pkg::P_W'(c);
      assign take = p[s2l_pkg::P_W-1:s2l_pkg::QB]
                    <= (s2l_pkg::P_W - s2l_pkg::QB)'(x_in);
      assign r_d[k][i]  = take ? c : r_in;
      assign sq_d[k][i] = take ? sq_c : sq_in;
      assign xr_d[k][i] = x_in;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      small_d[i] = xr_q[NR-1][i] <= s2l_pkg::EPS_X;
      n_d[i]     = s2l_pkg::N_W'(s2l_pkg::KAPPA) * s2l_pkg::N_W'(xr_q[NR-1][i][s2l_pkg::EPS_W-1:0])
                 + s2l_pkg::LIN_OFS;
      lp[i]      = s2l_pkg::LP_W'(n8_q[i]) * s2l_pkg::LP_W'(s2l_pkg::RECIP_145);
      f_d[i]     = small_q[i] ? s2l_pkg::F_W'(lp[i] >> s2l_pkg::RECIP_SH) : rt_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NR; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (rdy[k]) begin
          r_q[k][i]  <= r_d[k][i];
          sq_q[k][i] <= sq_d[k][i];
          xr_q[k][i] <= xr_d[k][i];
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (rdy[NR]) begin
        small_q[i] <= small_d[i];
        n8_q[i]    <= n_d[i][s2l_pkg::N_W-1:3];
        rt_q[i]    <= r_q[NR-1][i];
      end
      if (rdy[NR+1]) begin
        f_q[i] <= f_d[i];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NS-1];
  assign f_o         = f_q;

endmodule

FILE: sv/s2l_lab.sv
// ----------------------------------------------------------------------------
// s2l_lab
// l*, a*, b* scaling, rounding and saturation into the output register
// ----------------------------------------------------------------------------
module s2l_lab (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [s2l_pkg::F_W-1:0]      f_i [3],
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [s2l_pkg::LIGHT_W-1:0]  lightness_o,
  output logic [s2l_pkg::CHROMA_W-1:0] green_red_o,
  output logic [s2l_pkg::CHROMA_W-1:0] blue_yellow_o
);

  localparam int NS = 2;

  logic [NS-1:0]                       vld_q;
  logic [NS:0]                         rdy;
  logic signed [s2l_pkg::V_W-1:0]      fs [3];
  logic signed [s2l_pkg::V_W-1:0]      v_d [3];
  logic signed [s2l_pkg::V_W-1:0]      v_q [3];
  logic [s2l_pkg::V_W-1:0]             mag [3];
  logic [s2l_pkg::V_W-1:0]             sum [3];
  logic [s2l_pkg::RM_W-1:0]            rm  [3];
  logic [s2l_pkg::LIGHT_W-1:0]         light_d;
  logic [s2l_pkg::CHROMA_W-1:0]        ch_d [2];
  logic [s2l_pkg::LIGHT_W-1:0]         light_q;
  logic [s2l_pkg::CHROMA_W-1:0]        gr_q;
  logic [s2l_pkg::CHROMA_W-1:0]        by_q;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fs[i] = $signed(s2l_pkg::V_W'(f_i[i]));
    end
    v_d[0] = fs[1] * $signed(s2l_pkg::V_W'(116))
           - $signed(s2l_pkg::V_W'(16) << s2l_pkg::QB);
    v_d[1] = (fs[0] - fs[1]) * $signed(s2l_pkg::V_W'(500));
    v_d[2] = (fs[1] - fs[2]) * $signed(s2l_pkg::V_W'(200));
  end

  // round half away from zero on the magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = v_q[i][s2l_pkg::V_W-1] ? s2l_pkg::V_W'(-v_q[i]) : s2l_pkg::V_W'(v_q[i]);
      sum[i] = mag[i] + (s2l_pkg::V_W'(1) << (s2l_pkg::SH - 1));
      rm[i]  = sum[i][s2l_pkg::V_W-1:s2l_pkg::SH];
    end
    if (v_q[0][s2l_pkg::V_W-1]) begin
      light_d = '0;
    end else if (rm[0] > s2l_pkg::RM_W'(s2l_pkg::L_MAX_I)) begin
      light_d = s2l_pkg::L_MAX;
    end else begin
      light_d = s2l_pkg::LIGHT_W'(rm[0]);
    end
    for (int i = 1; i < 3; i++) begin
      if (v_q[i][s2l_pkg::V_W-1]) begin
        if (rm[i] > s2l_pkg::RM_W'(s2l_pkg::CH_MIN_MAG_I)) begin
          ch_d[i-1] = s2l_pkg::CHROMA_W'(-s2l_pkg::CH_MIN_MAG_I);
        end else begin
          ch_d[i-1] = s2l_pkg::CHROMA_W'(s2l_pkg::RM_W'(0) - rm[i]);
        end
      end else if (rm[i] > s2l_pkg::RM_W'(s2l_pkg::CH_MAX_I)) begin
        ch_d[i-1] = s2l_pkg::CHROMA_W'(s2l_pkg::CH_MAX_I);
      end else begin
        ch_d[i-1] = s2l_pkg::CHROMA_W'(rm[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      if (rdy[1]) begin
        vld_q[1] <= vld_q[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      v_q <= v_d;
    end
    if (rdy[1]) begin
      light_q <= light_d;
      gr_q    <= ch_d[0];
      by_q    <= ch_d[1];
    end
  end

  assign in_ready_o    = rdy[0];
  assign out_valid_o   = vld_q[NS-1];
  assign lightness_o   = light_q;
  assign green_red_o   = gr_q;
  assign blue_yellow_o = by_q;

endmodule

FILE: sv/srgb_to_cielab.sv
// ----------------------------------------------------------------------------
// srgb_to_cielab
// 8-bit srgb pixel to cielab under the d65 white, fixed point outputs
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the whole pipe is stalled, and returns
// L*, a* and b* scaled by 2^7, rounded and saturated, through the decode
// table and matrix, the bit-per-stage cube root, the linear branch of f
// and scaling into the output register. Every stage holds its request
// when the next one is full, so gaps in the stream are squeezed out and
// the input stays ready while a result waits, until the pipe is full.
module srgb_to_cielab (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [s2l_pkg::CODE_W-1:0]   blue_i,
  input  logic [s2l_pkg::CODE_W-1:0]   green_i,
  input  logic [s2l_pkg::CODE_W-1:0]   red_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [s2l_pkg::LIGHT_W-1:0]  lightness_o,
  output logic [s2l_pkg::CHROMA_W-1:0] green_red_o,
  output logic [s2l_pkg::CHROMA_W-1:0] blue_yellow_o
);

  logic                    mat_valid;
  logic                    mat_ready;
  logic [s2l_pkg::X_W-1:0] xyz [3];
  logic                    f_valid;
  logic                    f_ready;
  logic [s2l_pkg::F_W-1:0] fxyz [3];

  s2l_linmat u_linmat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (mat_valid),
    .out_ready_i (mat_ready),
    .x_o         (xyz)
  );

  s2l_cief u_cief (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mat_valid),
    .in_ready_o  (mat_ready),
    .x_i         (xyz),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .f_o         (fxyz)
  );

  s2l_lab u_lab (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (f_valid),
    .in_ready_o    (f_ready),
    .f_i           (fxyz),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .lightness_o   (lightness_o),
    .green_red_o   (green_red_o),
    .blue_yellow_o (blue_yellow_o)
  );

  // input only backs up when the whole pipe is full behind a stalled output
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  a_light_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lightness_o <= s2l_pkg::L_MAX))
    else $error("lightness above saturation limit");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && !f_ready) |=> f_valid)
    else $error("cube root output dropped while stalled");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the srgb to cielab pixel converter
// ----------------------------------------------------------------------------
// A directed table of pixels comes first: black, white, the primaries, the
// gamma knee and the chroma extremes. Random pixels follow, sent in phases
// with different idle and stall patterns. One phase holds the output back
// for a long stretch so the pipe fills up. Every result is checked: black
// against the table, the rest against a bench fixed-point conversion model.
// ----------------------------------------------------------------------------
module testbench;

  localparam int ONE_Q    = 1 << s2l_pkg::QB;
  localparam int WD_LIMIT = 4000;

  typedef struct packed {
    logic [s2l_pkg::LIGHT_W-1:0]  lightness;
    logic [s2l_pkg::CHROMA_W-1:0] green_red;
    logic [s2l_pkg::CHROMA_W-1:0] blue_yellow;
  } lab_t;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    bit         known;
    lab_t       lab;
  } pixel_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] blue_i = '0;
  logic [7:0] green_i = '0;
  logic [7:0] red_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [s2l_pkg::LIGHT_W-1:0] lightness_o;
  logic [s2l_pkg::CHROMA_W-1:0] green_red_o;
  logic [s2l_pkg::CHROMA_W-1:0] blue_yellow_o;

  lab_t       lab_queue[$];
  longint     linear_of[256];
  int         errors = 0;
  int         pixels_sent = 0;
  int         pixels_checked = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         hold_cycles = 0;
  int         quiet_cycles = 0;

  srgb_to_cielab i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint q_mul(longint x, longint y);
    return (x * y) >>> s2l_pkg::QB;
  endfunction

  function automatic longint fifth_root(longint s);
    longint r, c, c2;
    r = 0;
    for (int k = s2l_pkg::QB; k >= 0; k--) begin
      c = r | (64'd1 << k);
      c2 = q_mul(c, c);
      if (c <= ONE_Q && q_mul(q_mul(c2, c2), c) <= s) r = c;
    end
    return r;
  endfunction

  function automatic longint cube_root(longint x);
    longint r, c;
    r = 0;
    for (int k = s2l_pkg::QB; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if (q_mul(q_mul(c, c), c) <= x) r = c;
    end
    return r;
  endfunction

  function automatic longint gamma_decode(int v);
    longint t, s;
    if (v <= 10) return (longint'(v) * ONE_Q * 20 + 32946) / 65892;
    t = ((1000 * longint'(v) + 14025) * ONE_Q * 2 + 269025) / 538050;
    s = q_mul(t, t);
    return q_mul(s, fifth_root(s));
  endfunction

  function automatic longint lab_f(longint x);
    if (x * 1000000 > 8856 * longint'(ONE_Q)) return cube_root(x);
    return (9033 * x + 160 * longint'(ONE_Q) + 580) / 1160;
  endfunction

  function automatic longint scale_round(longint v);
    longint half;
    half = longint'(1) << (s2l_pkg::QB - s2l_pkg::FRAC_BITS - 1);
    if (v >= 0) return (v + half) >>> (s2l_pkg::QB - s2l_pkg::FRAC_BITS);
    return -((-v + half) >>> (s2l_pkg::QB - s2l_pkg::FRAC_BITS));
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic lab_t srgb_to_lab(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    longint lin[3], f[3], acc, l, a, bb;
    lab_t   res;
    lin[0] = linear_of[r];
    lin[1] = linear_of[g];
    lin[2] = linear_of[b];
    for (int i = 0; i < 3; i++) begin
      acc = lin[0] * longint'(s2l_pkg::MAT[i][0]) + lin[1] * longint'(s2l_pkg::MAT[i][1])
          + lin[2] * longint'(s2l_pkg::MAT[i][2]);
      f[i] = lab_f((acc + (ONE_Q >> 1)) >>> s2l_pkg::QB);
    end
    l  = clip(scale_round(116 * f[1] - 16 * longint'(ONE_Q)), 0, s2l_pkg::L_MAX_I);
    a  = clip(scale_round(500 * (f[0] - f[1])), -s2l_pkg::CH_MIN_MAG_I,
              s2l_pkg::CH_MAX_I);
    bb = clip(scale_round(200 * (f[1] - f[2])), -s2l_pkg::CH_MIN_MAG_I,
              s2l_pkg::CH_MAX_I);
    res.lightness   = l[s2l_pkg::LIGHT_W-1:0];
    res.green_red   = a[s2l_pkg::CHROMA_W-1:0];
    res.blue_yellow = bb[s2l_pkg::CHROMA_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             field, pixels_checked, got, want);
    errors++;
  endtask

  // request side, valid stays up between back-to-back pixels
  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, bit known,
                            lab_t want);
    @(negedge clk_i);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    blue_i     <= b;
    green_i    <= g;
    red_i      <= r;
    do @(posedge clk_i); while (!in_ready_o);
    lab_queue.push_back(known ? want : srgb_to_lab(b, g, r));
    pixels_sent++;
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++)
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 0, '0);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lab_queue.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lab_queue.size() == 0) begin
        $display("result with no pixel pending");
        errors++;
      end else begin
        lab_t want;
        want = lab_queue.pop_front();
        if (lightness_o !== want.lightness)
          report_mismatch("lightness", lightness_o, want.lightness);
        if (green_red_o !== want.green_red)
          report_mismatch("green_red", $signed(green_red_o), $signed(want.green_red));
        if (blue_yellow_o !== want.blue_yellow)
          report_mismatch("blue_yellow", $signed(blue_yellow_o), $signed(want.blue_yellow));
      end
      pixels_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WD_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    pixel_row_t table_rows[$];
    for (int v = 0; v < 256; v++) linear_of[v] = gamma_decode(v);

    table_rows = '{
      '{8'd0,   8'd0,   8'd0,   1, '{14'd0, 15'd0, 15'd0}},
      '{8'd255, 8'd255, 8'd255, 0, '0},
      '{8'd0,   8'd0,   8'd255, 0, '0},
      '{8'd0,   8'd255, 8'd0,   0, '0},
      '{8'd255, 8'd0,   8'd0,   0, '0},
      '{8'd255, 8'd0,   8'd255, 0, '0},
      '{8'd0,   8'd255, 8'd255, 0, '0},
      '{8'd255, 8'd255, 8'd0,   0, '0},
      '{8'd10,  8'd10,  8'd10,  0, '0},
      '{8'd11,  8'd11,  8'd11,  0, '0},
      '{8'd1,   8'd1,   8'd1,   0, '0},
      '{8'd20,  8'd20,  8'd20,  0, '0},
      '{8'd24,  8'd24,  8'd24,  0, '0},
      '{8'd128, 8'd128, 8'd128, 0, '0},
      '{8'd254, 8'd254, 8'd254, 0, '0},
      '{8'd10,  8'd11,  8'd10,  0, '0},
      '{8'd0,   8'd10,  8'd255, 0, '0},
      '{8'd255, 8'd10,  8'd0,   0, '0},
      '{8'd170, 8'd85,  8'd170, 0, '0},
      '{8'd85,  8'd170, 8'd85,  0, '0}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (table_rows[i])
      send_pixel(table_rows[i].blue, table_rows[i].green, table_rows[i].red,
                 table_rows[i].known, table_rows[i].lab);

    idle_pct = 0;  stall_pct = 0;  send_random(330);
    idle_pct = 66; stall_pct = 0;  send_random(250);
    // sender pauses until everything is back
    drain();
    idle_pct = 0;  stall_pct = 66; send_random(250);
    idle_pct = 6;  stall_pct = 6;  send_random(250);
    // long output hold while pixels keep coming, pipe fills and stalls
    idle_pct = 0;  stall_pct = 0;  hold_cycles = 300;
    send_random(150);
    idle_pct = 66; stall_pct = 66; send_random(120);

    drain();
    repeat (40) @(posedge clk_i);
    $display("sent %0d pixels, checked %0d results across idle and stall mixes",
             pixels_sent, pixels_checked);
    $display("included gamma knee, primaries, white, black and a full-pipe stall");
    if (errors == 0 && lab_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
